// ===== src/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, codes and ring-index helpers for the bounded deque block.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Store size and derived widths
    localparam int CAPACITY    = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed beat field widths
    localparam int REQ_W       = 2;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_FRONT = 2'd0,
        REQ_ADD_BACK  = 2'd1,
        REQ_REMOVE    = 2'd2,
        REQ_SEARCH    = 2'd3
    } t_req_type;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_DONE
    } t_state;

    // Next ring position
    function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] a);
        return (a == ADDR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    // Previous ring position
    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? ADDR_W'(CAPACITY - 1) : a - 1'b1;
    endfunction

    // front + offset, wrapped; offset is below CAPACITY so one subtract suffices
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(a) + (ADDR_W+1)'(b);
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/bdq_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if / bdq_rsp_if
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface bdq_req_if;
    import bdq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bdq_rsp_if;
    import bdq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [COUNT_OUT_W-1:0] count;
    logic                   is_empty;

    modport source (output valid, output status, output found, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input found, input count,
                    input is_empty, output ready);
endinterface

// ===== src/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bounded_deque_with_search_top.sv =====
// Add front / add back / remove last: response registered in S_EXEC when the slot is free.
// Search: one RAM read per stored entry, walking front to back, stopping at the first match;
// an empty search answers from S_EXEC without a walk.
// One request in work at a time, a new one taken while a response waits; a new request
// is taken only back in S_IDLE, and output stalls hold the block in S_EXEC or S_DONE.
// Sync active-low reset empties the deque, drops any pending response, leaves the RAM as is.
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top
// Bounded ring deque of signed 32-bit values with front-to-back linear search.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdq_req_if.sink    i_req,
    bdq_rsp_if.source  o_rsp
);
    import bdq_pkg::*;

    // Control state
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;

    // Request and search working registers
    t_req_type          r_req_type, n_req_type;
    logic [VAL_W-1:0]   r_value, n_value;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0]  r_left, n_left;
    logic               r_found, n_found;

    // Response payload
    t_status            r_out_status;
    logic               r_out_found;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic               r_out_empty;

    // RAM port signals
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    logic               slot_free;
    logic               load_out;
    t_status            out_status;
    logic               out_found;
    logic               is_full;

    bdq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free = !r_out_valid || o_rsp.ready;
    assign is_full   = (r_count == CNT_W'(CAPACITY));

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_req_type  = r_req_type;
        n_value     = r_value;
        n_pos       = r_pos;
        n_left      = r_left;
        n_found     = r_found;
        ram_we      = 1'b0;
        ram_waddr   = r_front;
        ram_raddr   = r_pos;
        load_out    = 1'b0;
        out_status  = ST_DONE;
        out_found   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req_type = t_req_type'(i_req.req_type);
                    n_value    = $unsigned(i_req.value);
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_found = 1'b0;
                case (r_req_type) inside
                    REQ_ADD_FRONT, REQ_ADD_BACK: begin
                        if (slot_free) begin
                            load_out = 1'b1;
                            n_state  = S_IDLE;
                            if (is_full) begin
                                out_status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                if (r_req_type == REQ_ADD_FRONT) begin
                                    ram_waddr = ring_dec(r_front);
                                    n_front   = ring_dec(r_front);
                                end else begin
                                    ram_waddr = ring_add(r_front, r_count);
                                end
                            end
                        end
                    end
                    REQ_REMOVE: begin
                        if (slot_free) begin
                            load_out = 1'b1;
                            n_state  = S_IDLE;
                            if (r_count == '0) begin
                                out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Search: empty store answers at once, else start the walk
                        if (r_count == '0) begin
                            if (slot_free) begin
                                load_out = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            ram_raddr = r_front;
                            n_pos     = ring_inc(r_front);
                            n_left    = ADDR_W'(r_count - 1'b1);
                            n_state   = S_SEARCH;
                        end
                    end
                endcase
            end
            S_SEARCH: begin
                // Compare entry read last cycle; issue the next read if still going
                if (ram_rdata == r_value) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (r_left == '0) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_pos;
                    n_pos     = ring_inc(r_pos);
                    n_left    = r_left - 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    load_out  = 1'b1;
                    out_found = r_found;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Response slot: filled on load, emptied when the beat is taken
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and response payload registers
    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_found    <= n_found;
        if (load_out) begin
            r_out_status <= out_status;
            r_out_found  <= out_found;
            r_out_count  <= COUNT_OUT_W'(n_count);
            r_out_empty  <= (n_count == '0);
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.count    = r_out_count;
    assign o_rsp.is_empty = r_out_empty;

endmodule

// ===== src/bdq_checker.sv =====
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the response channel of the bounded deque.
// ----------------------------------------------------------------------------
module bdq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [bdq_pkg::STATUS_W-1:0]    i_rsp_status,
    input logic                            i_rsp_found,
    input logic [bdq_pkg::COUNT_OUT_W-1:0] i_rsp_count,
    input logic                            i_rsp_is_empty
);
    import bdq_pkg::*;

    // Held response beat stays up
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    // Empty flag agrees with count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_is_empty == (i_rsp_count == '0)))
        else $error("is_empty disagrees with count");

    // Only a completed search may report a hit
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_found |-> (i_rsp_status == ST_DONE) && !i_rsp_is_empty)
        else $error("found flagged on refused or empty response");

    // Full refusal only at capacity, empty refusal only at zero
    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            ((i_rsp_status != ST_FULL) || (i_rsp_count == COUNT_OUT_W'(CAPACITY))) &&
            ((i_rsp_status != ST_EMPTY) || i_rsp_is_empty))
        else $error("refusal status inconsistent with count");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (CAPACITY > 31) || (i_rsp_count <= COUNT_OUT_W'(CAPACITY)))
        else $error("count beyond capacity");

endmodule

bind bounded_deque_with_search_top bdq_checker u_bdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_found    (o_rsp.found),
    .i_rsp_count    (o_rsp.count),
    .i_rsp_is_empty (o_rsp.is_empty)
);

// ===== dv/bounded_deque_with_search_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top_tb
// Self-checking bench for the bounded deque. A shadow ring deque predicts the
// response beat of every request. A short directed table comes first, with
// reset, extreme values, full and empty refusals and searches on a full store.
// A long random run follows, with add/remove bias phases that sweep the fill
// level from empty to full. Both channels idle at random.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top_tb;
    import bdq_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    // Response beat as the bench expects it
    typedef struct {
        t_status                status;
        logic                   found;
        logic [COUNT_OUT_W-1:0] count;
        logic                   is_empty;
    } t_rsp_beat;

    // One row of the directed table; reps repeats the same request
    typedef struct {
        t_req_type        kind;
        logic [VAL_W-1:0] val;
        int               reps;
        bit               typed;
        t_status          st;
        logic             fnd;
        int               cnt;
    } t_dir_row;

    localparam int DIR_N = 22;

    t_dir_row dir_rows [DIR_N] = '{
        '{REQ_SEARCH,    32'h0000_0000, 1,  1'b1, ST_DONE,  1'b0, 0},
        '{REQ_REMOVE,    32'h0000_0000, 1,  1'b1, ST_EMPTY, 1'b0, 0},
        '{REQ_ADD_FRONT, 32'h8000_0000, 1,  1'b1, ST_DONE,  1'b0, 1},
        '{REQ_SEARCH,    32'h8000_0000, 1,  1'b1, ST_DONE,  1'b1, 1},
        '{REQ_ADD_BACK,  32'h7FFF_FFFF, 1,  1'b1, ST_DONE,  1'b0, 2},
        '{REQ_SEARCH,    32'h7FFF_FFFF, 1,  1'b1, ST_DONE,  1'b1, 2},
        '{REQ_SEARCH,    32'h0000_0000, 1,  1'b1, ST_DONE,  1'b0, 2},
        '{REQ_REMOVE,    32'hFFFF_FFFF, 1,  1'b1, ST_DONE,  1'b0, 1},
        '{REQ_SEARCH,    32'h7FFF_FFFF, 1,  1'b1, ST_DONE,  1'b0, 1},
        '{REQ_REMOVE,    32'h0000_0000, 1,  1'b1, ST_DONE,  1'b0, 0},
        '{REQ_SEARCH,    32'h8000_0000, 1,  1'b1, ST_DONE,  1'b0, 0},
        '{REQ_ADD_BACK,  32'hFFFF_FFFF, 1,  1'b1, ST_DONE,  1'b0, 1},
        '{REQ_ADD_FRONT, 32'h0000_0001, 7,  1'b0, ST_DONE,  1'b0, 0},
        '{REQ_ADD_BACK,  32'h5A5A_A5A5, 8,  1'b0, ST_DONE,  1'b0, 0},
        '{REQ_ADD_FRONT, 32'h0000_0000, 1,  1'b1, ST_FULL,  1'b0, CAPACITY},
        '{REQ_ADD_BACK,  32'h0000_0000, 1,  1'b1, ST_FULL,  1'b0, CAPACITY},
        '{REQ_SEARCH,    32'h5A5A_A5A5, 1,  1'b0, ST_DONE,  1'b0, 0},
        '{REQ_SEARCH,    32'hFFFF_FFFF, 1,  1'b0, ST_DONE,  1'b0, 0},
        '{REQ_SEARCH,    32'h1234_5678, 1,  1'b0, ST_DONE,  1'b0, 0},
        '{REQ_SEARCH,    32'h0000_0001, 1,  1'b0, ST_DONE,  1'b0, 0},
        '{REQ_REMOVE,    32'hA5A5_5A5A, 16, 1'b0, ST_DONE,  1'b0, 0},
        '{REQ_REMOVE,    32'h0000_0000, 1,  1'b1, ST_EMPTY, 1'b0, 0}
    };

    // Values that searches and adds favour so that hits are common
    localparam logic [VAL_W-1:0] VAL_POOL [6] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0001, 32'hDEAD_BEEF
    };

    logic i_clk;
    logic i_rst_n;

    bdq_req_if req_if ();
    bdq_rsp_if rsp_if ();

    bounded_deque_with_search_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the deque
    logic [VAL_W-1:0] shadow_vals [CAPACITY];
    int               shadow_front;
    int               shadow_cnt;

    t_rsp_beat rsp_due_q [$];
    t_rsp_beat due_beat;

    int  mismatch_cnt;
    int  cycle_cnt;
    bit  req_quiet;
    bit  rsp_quiet;
    int  kind_cnt [4];
    int  hit_cnt;
    int  full_refusals;
    int  empty_refusals;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, rsp_due_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int draw_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the shadow deque and return its response beat
    function automatic t_rsp_beat apply_to_shadow_deque(t_req_type kind,
                                                        logic [VAL_W-1:0] v);
        t_rsp_beat r;
        r.status = ST_DONE;
        r.found  = 1'b0;
        case (kind)
            REQ_ADD_FRONT: begin
                if (shadow_cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
                    shadow_vals[shadow_front] = v;
                    shadow_cnt++;
                end
            end
            REQ_ADD_BACK: begin
                if (shadow_cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_vals[(shadow_front + shadow_cnt) % CAPACITY] = v;
                    shadow_cnt++;
                end
            end
            REQ_REMOVE: begin
                if (shadow_cnt == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_cnt--;
            end
            default: begin
                for (int i = 0; i < shadow_cnt; i++) begin
                    if (shadow_vals[(shadow_front + i) % CAPACITY] == v)
                        r.found = 1'b1;
                end
            end
        endcase
        r.count    = COUNT_OUT_W'(shadow_cnt);
        r.is_empty = (shadow_cnt == 0);
        return r;
    endfunction

    // Drive one request beat; on acceptance queue the beat it should produce
    task automatic send_req(t_req_type kind, logic [VAL_W-1:0] v, bit typed,
                            t_rsp_beat typed_beat);
        int        gap;
        t_rsp_beat pred;
        gap = draw_gap(req_quiet);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.value    <= v;
        do @(posedge i_clk); while (!req_if.ready);
        pred = apply_to_shadow_deque(kind, v);
        rsp_due_q.push_back(typed ? typed_beat : pred);
        kind_cnt[kind]++;
        if (pred.found)
            hit_cnt++;
        if (pred.status == ST_FULL)
            full_refusals++;
        if (pred.status == ST_EMPTY)
            empty_refusals++;
    endtask

    // Random value: fresh, from the pool, or one currently stored
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 || (r >= 60 && shadow_cnt == 0))
            return $urandom;
        if (r < 60)
            return VAL_POOL[$urandom_range(0, 5)];
        return shadow_vals[(shadow_front + $urandom_range(0, shadow_cnt - 1)) % CAPACITY];
    endfunction

    // Response ready: random stalls, with stretches of none
    initial begin : rsp_backpressure
        int hold;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0)
                rsp_quiet = ~rsp_quiet;
            hold = draw_gap(rsp_quiet);
            if (hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Response check against the oldest expected beat
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_due_q.size() == 0) begin
                $error("response beat with nothing expected (status %0d count %0d)",
                       rsp_if.status, rsp_if.count);
                mismatch_cnt++;
            end else begin
                due_beat = rsp_due_q.pop_front();
                if (rsp_if.status !== due_beat.status) begin
                    $error("status: expected %0d, got %0d", due_beat.status, rsp_if.status);
                    mismatch_cnt++;
                end
                if (rsp_if.found !== due_beat.found) begin
                    $error("found: expected %0d, got %0d", due_beat.found, rsp_if.found);
                    mismatch_cnt++;
                end
                if (rsp_if.count !== due_beat.count) begin
                    $error("count: expected %0d, got %0d", due_beat.count, rsp_if.count);
                    mismatch_cnt++;
                end
                if (rsp_if.is_empty !== due_beat.is_empty) begin
                    $error("is_empty: expected %0d, got %0d",
                           due_beat.is_empty, rsp_if.is_empty);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : main_seq
        t_rsp_beat typed_beat;
        t_req_type kind;
        int        add_pct;
        int        r;

        mismatch_cnt   = 0;
        cycle_cnt      = 0;
        req_quiet      = 1'b0;
        rsp_quiet      = 1'b0;
        hit_cnt        = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        kind_cnt       = '{0, 0, 0, 0};
        shadow_front   = 0;
        shadow_cnt     = 0;
        add_pct        = 50;

        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_ADD_FRONT;
        req_if.value    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[n]) begin
            typed_beat.status   = dir_rows[n].st;
            typed_beat.found    = dir_rows[n].fnd;
            typed_beat.count    = COUNT_OUT_W'(dir_rows[n].cnt);
            typed_beat.is_empty = (dir_rows[n].cnt == 0);
            repeat (dir_rows[n].reps)
                send_req(dir_rows[n].kind, dir_rows[n].val, dir_rows[n].typed, typed_beat);
        end

        // Random part: bias phases push the fill level between empty and full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                r = $urandom_range(0, 2);
                add_pct = (r == 0) ? 20 : (r == 1) ? 50 : 85;
            end
            if ($urandom_range(0, 79) == 0)
                req_quiet = ~req_quiet;
            r = $urandom_range(0, 99);
            if (r < 30)
                kind = REQ_SEARCH;
            else if ($urandom_range(0, 99) < add_pct)
                kind = $urandom_range(0, 1) ? REQ_ADD_BACK : REQ_ADD_FRONT;
            else
                kind = REQ_REMOVE;
            send_req(kind, pick_value(), 1'b0, typed_beat);
        end
        req_if.valid <= 1'b0;

        // Drain, then watch for stray beats
        while (rsp_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d front adds, %0d back adds, %0d removals, %0d searches",
                 kind_cnt[REQ_ADD_FRONT], kind_cnt[REQ_ADD_BACK],
                 kind_cnt[REQ_REMOVE], kind_cnt[REQ_SEARCH]);
        $display("%0d search hits, %0d adds refused as full, %0d removals refused as empty",
                 hit_cnt, full_refusals, empty_refusals);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
